/* rtl/pid_controller_dual_mode_core_assert.svh */
// Assertion macros used by the dual-mode PID controller top module.
`ifndef PID_CONTROLLER_DUAL_MODE_CORE_ASSERT_SVH
`define PID_CONTROLLER_DUAL_MODE_CORE_ASSERT_SVH

// Same-cycle implication, checked on i_clk outside reset.
`define PDM_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk outside reset.
`define PDM_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pid_dm_pkg.sv */
// Types and constants for the dual-mode PID controller.
package pid_dm_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int IN_W    = 16;
    localparam int ERR_W   = 17;
    localparam int GAIN_W  = 24;
    localparam int SUM_W   = 24;
    localparam int DB_W    = 16;
    localparam int ILIM_W  = 23;
    localparam int DLIM_W  = 20;
    localparam int DRV_W   = 21;
    localparam int FRAC_W  = 16;
    localparam int ACC_W   = 37;
    localparam int PROD_W  = 48;
    localparam int MAC_W   = 51;

    localparam logic [ILIM_W-1:0] ILIM_RST = '1;
    localparam logic [DLIM_W-1:0] DLIM_RST = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE           = 3'd0,
        REG_GAIN_P         = 3'd1,
        REG_GAIN_I         = 3'd2,
        REG_GAIN_D         = 3'd3,
        REG_DEAD_BAND      = 3'd4,
        REG_INTEGRAL_LIMIT = 3'd5,
        REG_DRIVE_LIMIT    = 3'd6
    } t_reg_idx;

    typedef enum logic {
        MODE_POSITIONAL  = 1'b0,
        MODE_INCREMENTAL = 1'b1
    } t_mode;

    typedef struct packed {
        t_mode                    mode;
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic [DB_W-1:0]          dead_band;
        logic [ILIM_W-1:0]        integral_limit;
        logic [DLIM_W-1:0]        drive_limit;
    } t_cfg;

endpackage

/* rtl/pid_dm_cfg.sv */
// Configuration register file of the dual-mode PID controller.
module pid_dm_cfg import pid_dm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode           <= MODE_POSITIONAL;
            r_cfg.gain_p         <= '0;
            r_cfg.gain_i         <= '0;
            r_cfg.gain_d         <= '0;
            r_cfg.dead_band      <= '0;
            r_cfg.integral_limit <= ILIM_RST;
            r_cfg.drive_limit    <= DLIM_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_index))
                REG_MODE:           r_cfg.mode           <= t_mode'(i_cfg_data[0]);
                REG_GAIN_P:         r_cfg.gain_p         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         r_cfg.gain_i         <= i_cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         r_cfg.gain_d         <= i_cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:      r_cfg.dead_band      <= i_cfg_data[DB_W-1:0];
                REG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_data[ILIM_W-1:0];
                REG_DRIVE_LIMIT:    r_cfg.drive_limit    <= i_cfg_data[DLIM_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/pid_dm_err.sv */
// Input stage: error forming, dead zone and the input register.
module pid_dm_err import pid_dm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic                    i_pass,
    input  t_cfg                    i_cfg,
    input  logic signed [IN_W-1:0]  i_setpoint,
    input  logic signed [IN_W-1:0]  i_measured,
    output logic                    o_valid,
    output logic signed [ERR_W-1:0] o_err
);

    logic                    r_valid;
    logic signed [ERR_W-1:0] r_err;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W:0]   err_x;
    logic signed [ERR_W:0]   band;
    logic signed [ERR_W-1:0] diff;

    always_comb begin
        diff  = {i_setpoint[IN_W-1], i_setpoint} - {i_measured[IN_W-1], i_measured};
        err_x = {diff[ERR_W-1], diff};
        band  = {2'b00, i_cfg.dead_band};
        // strict dead zone, positional mode only
        if (i_cfg.mode == MODE_POSITIONAL && err_x > -band && err_x < band) begin
            n_err = '0;
        end else begin
            n_err = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_pass) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_err <= n_err;
        end
    end

    assign o_valid = r_valid;
    assign o_err   = r_err;

endmodule

/* rtl/pid_dm_core.sv */
// Control law stage: three multipliers, accumulation, clamps, state and result register.
module pid_dm_core import pid_dm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_advance,
    input  t_cfg                    i_cfg,
    input  logic signed [ERR_W-1:0] i_err,
    output logic signed [DRV_W-1:0] o_drive
);

    logic signed [SUM_W-1:0]  r_err_sum;
    logic signed [ERR_W-1:0]  r_e1;
    logic signed [ERR_W-1:0]  r_e2;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DRV_W-1:0]  r_drive;

    logic signed [SUM_W-1:0]  n_err_sum;
    logic signed [ERR_W-1:0]  n_e2;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [DRV_W-1:0]  n_drive;

    logic signed [ERR_W:0]    diff1;
    logic signed [ERR_W+1:0]  diff2;
    logic signed [SUM_W:0]    sum_raw;
    logic signed [SUM_W:0]    lim_i;
    logic signed [SUM_W:0]    nlim_i;
    logic signed [SUM_W-1:0]  sum_new;
    logic signed [GAIN_W-1:0] op_p;
    logic signed [GAIN_W-1:0] op_i;
    logic signed [GAIN_W-1:0] op_d;
    logic signed [GAIN_W-1:0] g_p;
    logic signed [GAIN_W-1:0] g_i;
    logic signed [GAIN_W-1:0] g_d;
    logic signed [PROD_W-1:0] prod_p;
    logic signed [PROD_W-1:0] prod_i;
    logic signed [PROD_W-1:0] prod_d;
    logic signed [MAC_W-1:0]  mac;
    logic signed [MAC_W-FRAC_W-1:0] q_pos;
    logic signed [MAC_W-FRAC_W-1:0] lim_q;
    logic signed [MAC_W-FRAC_W-1:0] nlim_q;
    logic signed [DRV_W-1:0]  drv_pos;
    logic signed [MAC_W-1:0]  acc_sum;
    logic signed [MAC_W-1:0]  lim_a;
    logic signed [MAC_W-1:0]  nlim_a;
    logic signed [ACC_W-1:0]  acc_inc;

    always_comb begin
        g_p = $signed(i_cfg.gain_p);
        g_i = $signed(i_cfg.gain_i);
        g_d = $signed(i_cfg.gain_d);

        diff1 = {i_err[ERR_W-1], i_err} - {r_e1[ERR_W-1], r_e1};
        diff2 = {{2{i_err[ERR_W-1]}}, i_err} - {r_e1[ERR_W-1], r_e1, 1'b0}
              + {{2{r_e2[ERR_W-1]}}, r_e2};

        // clamped error sum, used only in positional mode
        sum_raw = {{(SUM_W+1-ERR_W){i_err[ERR_W-1]}}, i_err}
                + {r_err_sum[SUM_W-1], r_err_sum};
        lim_i   = {2'b00, i_cfg.integral_limit};
        nlim_i  = -lim_i;
        if (sum_raw > lim_i) begin
            sum_new = lim_i[SUM_W-1:0];
        end else if (sum_raw < nlim_i) begin
            sum_new = nlim_i[SUM_W-1:0];
        end else begin
            sum_new = sum_raw[SUM_W-1:0];
        end

        if (i_cfg.mode == MODE_POSITIONAL) begin
            op_p = {{(GAIN_W-ERR_W){i_err[ERR_W-1]}}, i_err};
            op_i = sum_new;
            op_d = {{(GAIN_W-ERR_W-1){diff1[ERR_W]}}, diff1};
        end else begin
            op_p = {{(GAIN_W-ERR_W-1){diff1[ERR_W]}}, diff1};
            op_i = {{(GAIN_W-ERR_W){i_err[ERR_W-1]}}, i_err};
            op_d = {{(GAIN_W-ERR_W-2){diff2[ERR_W+1]}}, diff2};
        end

        prod_p = op_p * g_p;
        prod_i = op_i * g_i;
        prod_d = op_d * g_d;

        mac = {{(MAC_W-PROD_W){prod_p[PROD_W-1]}}, prod_p}
            + {{(MAC_W-PROD_W){prod_i[PROD_W-1]}}, prod_i}
            + {{(MAC_W-PROD_W){prod_d[PROD_W-1]}}, prod_d};

        // positional: floor to integer, then clamp
        q_pos  = mac[MAC_W-1:FRAC_W];
        lim_q  = {{(MAC_W-FRAC_W-DLIM_W){1'b0}}, i_cfg.drive_limit};
        nlim_q = -lim_q;
        if (q_pos > lim_q) begin
            drv_pos = lim_q[DRV_W-1:0];
        end else if (q_pos < nlim_q) begin
            drv_pos = nlim_q[DRV_W-1:0];
        end else begin
            drv_pos = q_pos[DRV_W-1:0];
        end

        // incremental: clamp the fractional accumulator
        acc_sum = {{(MAC_W-ACC_W){r_acc[ACC_W-1]}}, r_acc} + mac;
        lim_a   = {{(MAC_W-DLIM_W-FRAC_W){1'b0}}, i_cfg.drive_limit, {FRAC_W{1'b0}}};
        nlim_a  = -lim_a;
        if (acc_sum > lim_a) begin
            acc_inc = lim_a[ACC_W-1:0];
        end else if (acc_sum < nlim_a) begin
            acc_inc = nlim_a[ACC_W-1:0];
        end else begin
            acc_inc = acc_sum[ACC_W-1:0];
        end

        if (i_cfg.mode == MODE_POSITIONAL) begin
            n_err_sum = sum_new;
            n_e2      = r_e2;
            n_acc     = {drv_pos, {FRAC_W{1'b0}}};
            n_drive   = drv_pos;
        end else begin
            n_err_sum = r_err_sum;
            n_e2      = r_e1;
            n_acc     = acc_inc;
            n_drive   = acc_inc[ACC_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err_sum <= '0;
            r_e1      <= '0;
            r_e2      <= '0;
            r_acc     <= '0;
        end else if (i_advance) begin
            r_err_sum <= n_err_sum;
            r_e1      <= i_err;
            r_e2      <= n_e2;
            r_acc     <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_drive <= n_drive;
        end
    end

    assign o_drive = r_drive;

endmodule

/* rtl/pid_controller_dual_mode_core.sv */
// Dual-mode PID controller: one setpoint/measured item in, one clamped drive item out.
// The block takes one item per clock cycle while the output is not stalled; each item
// passes the input register, then the result register. The first stage forms the error and the
// dead zone; the second stage runs three parallel 24x24 multipliers, the adder, the
// clamps and the controller state update, so the state feedback closes within that
// one stage and consecutive items need no gap. A stalled output holds its item while
// the first stage still takes one more item. Configuration writes are expected only
// while no item is in flight.
module pid_controller_dual_mode_core import pid_dm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [IN_W-1:0]  i_setpoint,
    input  logic signed [IN_W-1:0]  i_measured,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [DRV_W-1:0] o_drive
);

    `include "pid_controller_dual_mode_core_assert.svh"

    t_cfg                    cfg;
    logic                    s1_valid;
    logic signed [ERR_W-1:0] s1_err;
    logic                    out_free;
    logic                    adv;
    logic                    in_acc;
    logic                    r_out_valid;
    logic signed [DRV_W:0]   drive_ext;
    logic signed [DRV_W:0]   drive_lim;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = s1_valid && out_free;
    assign o_in_stall = s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    pid_dm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    pid_dm_err u_err (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (in_acc),
        .i_pass     (adv),
        .i_cfg      (cfg),
        .i_setpoint (i_setpoint),
        .i_measured (i_measured),
        .o_valid    (s1_valid),
        .o_err      (s1_err)
    );

    pid_dm_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (adv),
        .i_cfg     (cfg),
        .i_err     (s1_err),
        .o_drive   (o_drive)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

    assign drive_ext = {o_drive[DRV_W-1], o_drive};
    assign drive_lim = {2'b00, cfg.drive_limit};

    `PDM_ASSERT_IMPLY(a_stall_only_full, o_in_stall, s1_valid && r_out_valid, "input stalled with room in the pipe")
    `PDM_ASSERT_NEXT(a_adv_fills_out, adv, r_out_valid, "item advanced but no result shown")
    `PDM_ASSERT_IMPLY(a_drive_in_limit, r_out_valid, drive_ext <= drive_lim && drive_ext >= -drive_lim, "drive outside limit")

endmodule

/* tb/pid_controller_dual_mode_core_checker.sv */
// Checker for the dual-mode PID controller: predicts each drive item and compares it.
module pid_controller_dual_mode_core_checker
    import pid_dm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic signed [IN_W-1:0]  i_setpoint,
    input  logic signed [IN_W-1:0]  i_measured,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [DRV_W-1:0] i_drive,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the control registers
    t_mode  ctl_mode;
    longint kp, ki, kd;
    longint db_thresh, sum_limit, out_limit;

    // shadow of the controller state
    longint err_sum, prev_err, prev_prev_err, drive_acc;

    logic signed [DRV_W-1:0] drive_q[$];
    int fails;

    function automatic longint clamp_sym(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Advances the controller state by one item and returns the drive it yields.
    function automatic logic signed [DRV_W-1:0] next_drive(logic signed [IN_W-1:0] sp,
                                                           logic signed [IN_W-1:0] ms);
        longint e, acc, drv;
        e = longint'(sp) - longint'(ms);
        if (ctl_mode == MODE_POSITIONAL) begin
            if (e > -db_thresh && e < db_thresh) e = 0;
            err_sum = clamp_sym(err_sum + e, sum_limit);
            acc = kp * e + ki * err_sum + kd * (e - prev_err);
            prev_err = e;
            drv = clamp_sym(acc >>> FRAC_W, out_limit);
            drive_acc = drv <<< FRAC_W;
        end else begin
            acc = kp * (e - prev_err) + ki * e + kd * (e - 2 * prev_err + prev_prev_err);
            prev_prev_err = prev_err;
            prev_err = e;
            drive_acc = clamp_sym(drive_acc + acc, out_limit <<< FRAC_W);
            drv = drive_acc >>> FRAC_W;
        end
        return drv[DRV_W-1:0];
    endfunction

    always @(posedge i_clk) begin : monitor
        logic signed [DRV_W-1:0] want;
        if (!i_rst_n) begin
            ctl_mode      = MODE_POSITIONAL;
            kp            = 0;
            ki            = 0;
            kd            = 0;
            db_thresh     = 0;
            sum_limit     = longint'(ILIM_RST);
            out_limit     = longint'(DLIM_RST);
            err_sum       = 0;
            prev_err      = 0;
            prev_prev_err = 0;
            drive_acc     = 0;
            drive_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    $error("drive item %0d arrived with none expected", i_drive);
                    fails++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_drive !== want) begin
                        $error("drive mismatch: expected %0d, actual %0d", want, i_drive);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                drive_q.push_back(next_drive(i_setpoint, i_measured));
            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_index))
                    REG_MODE:           ctl_mode  = t_mode'(i_cfg_data[0]);
                    REG_GAIN_P:         kp        = longint'($signed(i_cfg_data[GAIN_W-1:0]));
                    REG_GAIN_I:         ki        = longint'($signed(i_cfg_data[GAIN_W-1:0]));
                    REG_GAIN_D:         kd        = longint'($signed(i_cfg_data[GAIN_W-1:0]));
                    REG_DEAD_BAND:      db_thresh = longint'(i_cfg_data[DB_W-1:0]);
                    REG_INTEGRAL_LIMIT: sum_limit = longint'(i_cfg_data[ILIM_W-1:0]);
                    REG_DRIVE_LIMIT:    out_limit = longint'(i_cfg_data[DLIM_W-1:0]);
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= drive_q.size();
    end

endmodule

/* tb/pid_controller_dual_mode_core_tb.sv */
// Testbench top for the dual-mode PID controller: stimulus, stalls, watchdog and verdict.
module pid_controller_dual_mode_core_tb import pid_dm_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LONG_HOLD_CYCLES = 40;
    localparam int QUIET_LIMIT      = 1000;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 70;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_stall;
    logic signed [IN_W-1:0]  i_setpoint;
    logic signed [IN_W-1:0]  i_measured;
    logic                    o_out_valid;
    logic                    i_out_stall;
    logic signed [DRV_W-1:0] o_drive;

    int fail_count;
    int pending;
    int quiet_cycles;
    bit no_gaps;
    int long_hold_reqs;

    logic signed [IN_W-1:0] last_sp, last_ms;
    logic [DB_W-1:0]        cur_dead_band;

    pid_controller_dual_mode_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_setpoint  (i_setpoint),
        .i_measured  (i_measured),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_drive     (o_drive)
    );

    pid_controller_dual_mode_core_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_setpoint   (i_setpoint),
        .i_measured   (i_measured),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_drive      (o_drive),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [IN_W-1:0] sat16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return 16'(v);
    endfunction

    function automatic logic signed [IN_W-1:0] pick_extreme();
        case ($urandom_range(0, 3))
            0:       return 16'sd32767;
            1:       return -16'sd32768;
            2:       return 16'sd0;
            default: return -16'sd1;
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 6))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'($urandom_range(0, 24'h020000));
            4:       return 24'(int'($urandom_range(0, 24'h040000)) - 24'h020000);
            default: return 24'($urandom);
        endcase
    endfunction

    // valid stays high after acceptance; the next item's gap lowers it
    task automatic send_item(input logic signed [IN_W-1:0] sp,
                             input logic signed [IN_W-1:0] ms);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        repeat (gap) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_setpoint <= sp;
        i_measured <= ms;
        last_sp = sp;
        last_ms = ms;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == REG_DEAD_BAND) cur_dead_band = val[DB_W-1:0];
    endtask

    task automatic cfg_close();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [CFG_DATA_W-1:0] db, il, dl;
        case ($urandom_range(0, 3))
            0:       db = '0;
            1:       db = 24'hFFFF;
            2:       db = 24'($urandom_range(0, 300));
            default: db = 24'($urandom & 32'hFFFF);
        endcase
        case ($urandom_range(0, 4))
            0:       il = '0;
            1:       il = 24'h7FFFFF;
            2,3:     il = 24'($urandom_range(0, 5000));
            default: il = 24'($urandom & 32'h7FFFFF);
        endcase
        case ($urandom_range(0, 4))
            0:       dl = '0;
            1:       dl = 24'hFFFFF;
            2,3:     dl = 24'($urandom_range(0, 5000));
            default: dl = 24'($urandom & 32'hFFFFF);
        endcase
        wait_idle();
        write_reg(REG_MODE, 24'($urandom_range(0, 1)));
        write_reg(REG_GAIN_P, pick_gain());
        write_reg(REG_GAIN_I, pick_gain());
        write_reg(REG_GAIN_D, pick_gain());
        write_reg(REG_DEAD_BAND, db);
        write_reg(REG_INTEGRAL_LIMIT, il);
        write_reg(REG_DRIVE_LIMIT, dl);
        cfg_close();
    endtask

    task automatic send_random_item();
        int off;
        logic signed [IN_W-1:0] sp, ms;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                sp = 16'($urandom);
                ms = 16'($urandom);
            end
            4, 5, 6: begin
                // measurement tracking the target closely
                off = $urandom_range(0, 600);
                sp  = 16'($urandom);
                ms  = sat16(int'(sp) + off - 300);
            end
            7: begin
                sp = pick_extreme();
                ms = pick_extreme();
            end
            8: begin
                off = $urandom_range(0, 100);
                sp  = last_sp;
                ms  = sat16(int'(last_ms) + off - 50);
            end
            default: begin
                // error just around the dead band edge
                off = int'(cur_dead_band) - 1 + int'($urandom_range(0, 2));
                if ($urandom_range(0, 1) == 1) off = -off;
                sp = 16'($urandom);
                ms = sat16(int'(sp) - off);
            end
        endcase
        send_item(sp, ms);
    endtask

    // receiver: random hold-off per item, plus one long hold per request
    initial begin : receiver
        int n;
        int holds_done;
        holds_done  = 0;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_reqs > holds_done) begin
                holds_done++;
                n = LONG_HOLD_CYCLES;
            end else begin
                n = no_gaps ? 0 : $urandom_range(0, 5);
            end
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int p, i;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_setpoint    = '0;
        i_measured    = '0;
        no_gaps       = 1'b0;
        cur_dead_band = '0;
        last_sp       = '0;
        last_ms       = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero gains give zero drive
        send_item(16'sd32767, -16'sd32768);
        send_item(16'sd0, 16'sd0);

        // positional mode with a dead band of 100
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_POSITIONAL));
        write_reg(REG_GAIN_P, 24'h010000);
        write_reg(REG_GAIN_I, 24'h000100);
        write_reg(REG_GAIN_D, 24'h008000);
        write_reg(REG_DEAD_BAND, 24'd100);
        write_reg(REG_INTEGRAL_LIMIT, 24'd1000);
        write_reg(REG_DRIVE_LIMIT, 24'hFFFFF);
        cfg_close();
        send_item(16'sd32767, -16'sd32768);
        send_item(-16'sd32768, 16'sd32767);
        send_item(16'sd50, -16'sd49);
        send_item(16'sd50, -16'sd50);
        send_item(-16'sd50, 16'sd49);
        send_item(-16'sd50, 16'sd50);
        send_item(16'sd1000, 16'sd0);
        send_item(16'sd32767, 16'sd32767);

        // mode switch alone: state carries over
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_INCREMENTAL));
        cfg_close();
        send_item(16'sd1000, 16'sd0);
        send_item(16'sd1000, 16'sd0);
        send_item(-16'sd32768, 16'sd32767);

        // extreme gains drive the accumulator into its clamp
        wait_idle();
        write_reg(REG_GAIN_P, 24'h7FFFFF);
        write_reg(REG_GAIN_I, 24'h800000);
        write_reg(REG_GAIN_D, 24'h7FFFFF);
        cfg_close();
        send_item(16'sd32767, -16'sd32768);
        send_item(-16'sd32768, 16'sd32767);
        send_item(16'sd0, 16'sd1);

        // widest dead band, zero integral limit
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_POSITIONAL));
        write_reg(REG_DEAD_BAND, 24'hFFFF);
        write_reg(REG_INTEGRAL_LIMIT, 24'd0);
        cfg_close();
        send_item(16'sd32767, -16'sd32767);
        send_item(16'sd32767, -16'sd32768);

        // zero drive limit in both modes
        wait_idle();
        write_reg(REG_DRIVE_LIMIT, 24'd0);
        cfg_close();
        send_item(-16'sd32768, 16'sd32767);
        wait_idle();
        write_reg(REG_MODE, CFG_DATA_W'(MODE_INCREMENTAL));
        cfg_close();
        send_item(16'sd5, 16'sd0);

        for (p = 0; p < PHASES; p++) begin
            random_config();
            no_gaps = (p % 4 == 2);
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (p % 2 == 1 && i == 10) long_hold_reqs++;
                if (p % 3 == 0 && i == 35) wait_idle();
                send_random_item();
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
